>>> design/bfnb_pkg.sv
// Package for the bitmap next-bit finder: sizes, op codes, payload structs
// and the sequencer state type.
// No dependencies; every other design file refers to it by scoped names.
package bfnb_pkg;

    // Bitmap geometry
    localparam int BITMAP_BITS = 1024;
    localparam int BYTE_BITS   = 8;
    localparam int STORE_BYTES = (BITMAP_BITS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int WORD_BITS   = 64;
    localparam int BYTE_LANES  = WORD_BITS / BYTE_BITS;
    localparam int NUM_WORDS   = BITMAP_BITS / WORD_BITS;
    localparam int WORD_AW     = $clog2(NUM_WORDS);
    localparam int LANE_W      = $clog2(BYTE_LANES);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int POS_W       = 11;
    localparam int IDX_W       = 7;

    // Op codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic             op;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       byte_data;
        logic             find_zero;
        logic [POS_W-1:0] start_bit;
        logic [POS_W-1:0] limit_bits;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } res_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

>>> design/bfnb_if.sv
// Valid/ready channel interfaces for commands and results.
// Depends on bfnb_pkg for the payload structs.
interface bfnb_cmd_if;
    logic          valid;
    logic          ready;
    bfnb_pkg::cmd_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bfnb_res_if;
    logic          valid;
    logic          ready;
    bfnb_pkg::res_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> design/bitmap_find_next_bit.sv
// Bitmap next-bit finder top level.
// Depends on bfnb_pkg and the channel interfaces in bfnb_if.sv.
//
// Usage:
//   cmd channel: a write transaction (op = write) stores one bitmap byte at
//   byte_index; it produces no result. A search
//   transaction (op = search) looks for the first bit at or after start_bit
//   and below min(limit_bits, 1024) that is set (find_zero = 0) or clear
//   (find_zero = 1).
//   res channel: one transaction per search: position of the match, or the
//   effective limit with found = 0.
//   The bitmap sits in a 16 x 64-bit memory with a registered read;
//   the search examines one 64-bit word per cycle, from the word holding
//   start_bit up to all 16 words when it crosses the whole map.
//   Reads of the next word are issued while the current one is checked.
//   cmd ready is low while a search runs; writes are taken back to back.
//   Reset clears the per-byte valid flags, so the whole bitmap reads as zero
//   at once; no clearing pass is needed.
//   If res is stalled, a finished search holds in the scan state until the
//   output register frees; one result may wait while new writes are taken.
module bitmap_find_next_bit (
    input  logic            clk,
    input  logic            rst_n,
    bfnb_cmd_if.sink        cmd,
    bfnb_res_if.source      res
);

    localparam int LIM_WW = bfnb_pkg::POS_W - bfnb_pkg::BIT_W;

    // Bitmap memory and per-byte valid flags
    logic [bfnb_pkg::WORD_BITS-1:0]   mem [bfnb_pkg::NUM_WORDS];
    logic [bfnb_pkg::STORE_BYTES-1:0] byte_valid_reg;
    logic [bfnb_pkg::WORD_BITS-1:0]   rd_data_reg;
    logic [bfnb_pkg::BYTE_LANES-1:0]  rd_valid_reg;
    logic [bfnb_pkg::WORD_AW-1:0]     rd_addr;

    // Sequencer and search context
    bfnb_pkg::state_t                 state_reg, state_next;
    logic [bfnb_pkg::WORD_AW-1:0]     word_reg;
    logic [bfnb_pkg::POS_W-1:0]       start_reg;
    logic [bfnb_pkg::POS_W-1:0]       lim_reg;
    logic                             find_zero_reg;
    logic                             empty_reg;

    // Output register
    logic                             res_valid_reg;
    logic [bfnb_pkg::POS_W-1:0]       pos_reg;
    logic                             found_reg;

    logic                             cmd_acc;
    logic                             wr_en;
    logic                             search_acc;
    logic [bfnb_pkg::WORD_AW-1:0]     wr_word;
    logic [bfnb_pkg::LANE_W-1:0]      wr_lane;
    logic [bfnb_pkg::POS_W-1:0]       lim_eff;
    logic                             out_free;
    logic                             finish;
    logic                             scan_done;
    logic                             advance;

    logic [bfnb_pkg::WORD_BITS-1:0]   eff_word;
    logic [bfnb_pkg::WORD_BITS-1:0]   cand;
    logic [bfnb_pkg::WORD_BITS-1:0]   in_range;
    logic [bfnb_pkg::BIT_W-1:0]       lo_bit;
    logic                             word_below_lim;
    logic [LIM_WW-1:0]                word_plus1;
    logic                             last_word;
    logic                             hit;
    logic [bfnb_pkg::BIT_W-1:0]       hit_idx;
    logic [bfnb_pkg::POS_W-1:0]       result_pos;

    assign cmd_acc    = cmd.valid && cmd.ready;
    assign wr_en      = cmd_acc && (cmd.payload.op == bfnb_pkg::OP_WRITE);
    assign search_acc = cmd_acc && (cmd.payload.op == bfnb_pkg::OP_SEARCH);
    assign wr_word    = cmd.payload.byte_index[bfnb_pkg::IDX_W-1:bfnb_pkg::LANE_W];
    assign wr_lane    = cmd.payload.byte_index[bfnb_pkg::LANE_W-1:0];
    assign out_free   = !res_valid_reg || res.ready;

    // Saturate the limit to the bitmap size
    assign lim_eff = (cmd.payload.limit_bits > bfnb_pkg::POS_W'(bfnb_pkg::BITMAP_BITS))
                   ? bfnb_pkg::POS_W'(bfnb_pkg::BITMAP_BITS) : cmd.payload.limit_bits;

    // Memory: byte-lane write, registered word read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_word][{wr_lane, 3'b000} +: bfnb_pkg::BYTE_BITS] <= cmd.payload.byte_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Valid flags make unwritten bytes read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= '0;
            rd_valid_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                byte_valid_reg[cmd.payload.byte_index] <= 1'b1;
            end
            rd_valid_reg <= byte_valid_reg[{rd_addr, {bfnb_pkg::LANE_W{1'b0}}}
                                           +: bfnb_pkg::BYTE_LANES];
        end
    end

    // Word check: mask out-of-range bits, find lowest match
    always_comb
    begin
        for (int l = 0; l < bfnb_pkg::BYTE_LANES; l++)
        begin
            eff_word[l*bfnb_pkg::BYTE_BITS +: bfnb_pkg::BYTE_BITS] =
                rd_valid_reg[l] ? rd_data_reg[l*bfnb_pkg::BYTE_BITS +: bfnb_pkg::BYTE_BITS]
                                : '0;
        end
        lo_bit = (word_reg == start_reg[bfnb_pkg::POS_W-2:bfnb_pkg::BIT_W])
               ? start_reg[bfnb_pkg::BIT_W-1:0] : '0;
        word_below_lim = {1'b0, word_reg} < lim_reg[bfnb_pkg::POS_W-1:bfnb_pkg::BIT_W];
        for (int i = 0; i < bfnb_pkg::WORD_BITS; i++)
        begin
            in_range[i] = (bfnb_pkg::BIT_W'(i) >= lo_bit)
                       && (word_below_lim
                           || (bfnb_pkg::BIT_W'(i) < lim_reg[bfnb_pkg::BIT_W-1:0]));
        end
        cand    = (find_zero_reg ? ~eff_word : eff_word) & in_range;
        hit     = |cand;
        hit_idx = '0;
        for (int i = bfnb_pkg::WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit_idx = bfnb_pkg::BIT_W'(i);
            end
        end
        word_plus1 = LIM_WW'({1'b0, word_reg}) + LIM_WW'(1);
        last_word  = {word_plus1, {bfnb_pkg::BIT_W{1'b0}}} >= lim_reg;
        result_pos = (empty_reg || !hit) ? lim_reg : {1'b0, word_reg, hit_idx};
    end

    assign finish = empty_reg || hit || last_word;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfnb_pkg::ST_IDLE:
            begin
                if (search_acc)
                begin
                    state_next = bfnb_pkg::ST_SCAN;
                end
            end
            bfnb_pkg::ST_SCAN:
            begin
                if (finish && out_free)
                begin
                    state_next = bfnb_pkg::ST_IDLE;
                end
            end
            default: state_next = bfnb_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        scan_done = 1'b0;
        advance   = 1'b0;
        rd_addr   = word_reg;
        unique case (state_reg)
            bfnb_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                rd_addr   = cmd.payload.start_bit[bfnb_pkg::POS_W-2:bfnb_pkg::BIT_W];
            end
            bfnb_pkg::ST_SCAN:
            begin
                scan_done = finish && out_free;
                advance   = !finish;
                rd_addr   = advance ? word_reg + bfnb_pkg::WORD_AW'(1) : word_reg;
            end
            default: cmd.ready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfnb_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (scan_done)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Search context and result payload
    always_ff @(posedge clk)
    begin
        if (search_acc)
        begin
            word_reg      <= cmd.payload.start_bit[bfnb_pkg::POS_W-2:bfnb_pkg::BIT_W];
            start_reg     <= cmd.payload.start_bit;
            lim_reg       <= lim_eff;
            find_zero_reg <= cmd.payload.find_zero;
            empty_reg     <= cmd.payload.start_bit >= lim_eff;
        end
        else if (advance)
        begin
            word_reg <= word_reg + bfnb_pkg::WORD_AW'(1);
        end
        if (scan_done)
        begin
            pos_reg   <= result_pos;
            found_reg <= hit && !empty_reg;
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.payload.position = pos_reg;
    assign res.payload.found    = found_reg;

endmodule

>>> design/bfnb_checker.sv
// Port-level checker for the bitmap next-bit finder, bound to the top level.
// Depends on bfnb_pkg and on bitmap_find_next_bit.
module bfnb_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    input  logic                       cmd_ready,
    input  logic                       cmd_op,
    input  logic                       res_valid,
    input  logic                       res_ready,
    input  logic [bfnb_pkg::POS_W-1:0] res_position,
    input  logic                       res_found
);

    // A stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_position) && $stable(res_found))
        else $error("result changed while stalled");

    // A found position lies inside the bitmap
    a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_found |-> res_position < bfnb_pkg::POS_W'(bfnb_pkg::BITMAP_BITS))
        else $error("found position outside bitmap");

    // A miss reports a position no greater than the bitmap size
    a_miss_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_found |-> res_position <= bfnb_pkg::POS_W'(bfnb_pkg::BITMAP_BITS))
        else $error("miss position above bitmap size");

    // A write never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_op == bfnb_pkg::OP_WRITE) && !res_valid
        |=> !res_valid)
        else $error("write produced a result");

    // A search blocks the command channel while it runs
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_op == bfnb_pkg::OP_SEARCH) |=> !cmd_ready)
        else $error("command accepted during a search");

endmodule

bind bitmap_find_next_bit bfnb_checker u_bfnb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .cmd_op       (cmd.payload.op),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_position (res.payload.position),
    .res_found    (res.payload.found)
);
